[rtl/mpfd_pkg.sv]
package mpfd_pkg;

  // Screen geometry and derived store size
  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int STORE_SIZE    = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
  localparam int ADDR_W        = $clog2(STORE_SIZE);
  // wide enough for any run address before the end-of-store check
  localparam int CALC_W        = $clog2(STORE_SIZE + 1024) + 1;
  // run counter: up to 128 pixels, 9 bits covers the signed length range
  localparam int CNT_W         = 9;

  // Command codes
  localparam logic [2:0] CMD_PLOT   = 3'd0;
  localparam logic [2:0] CMD_HLINE  = 3'd1;
  localparam logic [2:0] CMD_VLINE  = 3'd2;
  localparam logic [2:0] CMD_INVERT = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [6:0]        pos_x;
    logic [5:0]        pos_y;
    logic signed [7:0] run_length;
    logic [7:0]        stipple;
  } cmd_in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       clipped;
  } res_t;

  // Engine status towards the top level
  typedef struct packed {
    logic idle;
    logic done;
    res_t res;
  } eng_stat_t;

  // Memory port requests from the engine
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[rtl/mono_page_framebuffer_draw_core.sv]
// Monochrome page-organised framebuffer drawing core, 128x64 pixels held in a
// 1024-byte store (byte address page*128 + x, bit y%8). One transaction is
// taken at a time, and each is worked through the single read-modify-write
// pipeline over the one memory, one byte per cycle. Clear sweeps the store
// one byte a cycle. After reset the same sweep runs, during which in_ready
// stays low. A finished result waits in the output register while the next
// command is accepted.
module mono_page_framebuffer_draw_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mpfd_pkg::cmd_in_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output mpfd_pkg::res_t    out_data
);
  import mpfd_pkg::*;

  mem_req_t  mem_req;
  eng_stat_t stat;
  logic [7:0] rd_data;
  logic       start;
  logic       res_free;
  logic       out_valid_r;
  res_t       out_data_r;

  assign in_ready = stat.idle;
  assign start    = in_valid && in_ready;
  assign res_free = !out_valid_r || out_ready;

  mpfd_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cmd_in   (in_data),
    .res_free (res_free),
    .rd_data  (rd_data),
    .mem_req  (mem_req),
    .stat     (stat)
  );

  mpfd_ram #(
    .DATA_W (8),
    .DEPTH  (STORE_SIZE),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_data_r <= stat.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/mpfd_ram.sv]
module mpfd_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // One write port, one registered read port; a read of the address being
  // written returns the old contents
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/mpfd_engine.sv]
module mpfd_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mpfd_pkg::cmd_in_t  cmd_in,
  input  logic               res_free,
  input  logic [7:0]         rd_data,
  output mpfd_pkg::mem_req_t mem_req,
  output mpfd_pkg::eng_stat_t stat
);
  import mpfd_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CLEAR  = 2'd1;
  localparam logic [1:0] ST_RUN    = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  localparam logic [1:0] STEP_BYTE  = 2'd0;
  localparam logic [1:0] STEP_ROW   = 2'd1;
  localparam logic [1:0] STEP_PIXEL = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CALC_W-1:0] addr_r, addr_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic [7:0]        pat_r, pat_nxt;
  logic [1:0]        step_r, step_nxt;
  logic              cap_r, cap_nxt;
  logic              clip_r, clip_nxt;
  logic [7:0]        rdbyte_r, rdbyte_nxt;
  logic [ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic              clr_cmd_r, clr_cmd_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic [ADDR_W-1:0] s1_addr_r, s1_addr_nxt;
  logic [7:0]        s1_mask_r, s1_mask_nxt;
  logic              s1_cap_r, s1_cap_nxt;
  logic              fwd_hit_r, fwd_hit_nxt;
  logic [7:0]        fwd_data_r, fwd_data_nxt;

  // Command decode
  logic              neg;
  logic [7:0]        len8;
  logic [7:0]        hstart;
  logic [CNT_W-1:0]  hcount;
  logic [CNT_W-1:0]  pos_count;
  logic [CALC_W-1:0] page_base;
  logic [7:0]        row_mask;
  logic [7:0]        s1_data;
  logic              done;

  assign neg       = cmd_in.run_length[7];
  assign len8      = $unsigned(cmd_in.run_length);
  assign hstart    = neg ? ({1'b0, cmd_in.pos_x} + len8) : {1'b0, cmd_in.pos_x};
  assign hcount    = neg ? (CNT_W'(256) - {1'b0, len8}) : {1'b0, len8};
  assign pos_count = neg ? '0 : {1'b0, len8};
  assign page_base = CALC_W'(cmd_in.pos_y[5:3]) * CALC_W'(SCREEN_WIDTH);
  assign row_mask  = 8'(1) << cmd_in.pos_y[2:0];

  // Read data with forwarding of a write that landed in the same cycle as the read
  assign s1_data = fwd_hit_r ? fwd_data_r : rd_data;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    addr_nxt     = addr_r;
    mask_nxt     = mask_r;
    pat_nxt      = pat_r;
    step_nxt     = step_r;
    cap_nxt      = cap_r;
    clip_nxt     = clip_r;
    rdbyte_nxt   = rdbyte_r;
    clr_addr_nxt = clr_addr_r;
    clr_cmd_nxt  = clr_cmd_r;
    s1_v_nxt     = 1'b0;
    s1_addr_nxt  = s1_addr_r;
    s1_mask_nxt  = s1_mask_r;
    s1_cap_nxt   = s1_cap_r;
    mem_req      = '0;
    done         = 1'b0;

    // Stage 1: modify and write back, or capture for a read
    if (s1_v_r) begin
      if (s1_cap_r) begin
        rdbyte_nxt = s1_data;
      end else begin
        mem_req.we    = 1'b1;
        mem_req.waddr = s1_addr_r;
        mem_req.wdata = s1_data ^ s1_mask_r;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          clip_nxt   = 1'b0;
          rdbyte_nxt = 8'h00;
          cap_nxt    = 1'b0;
          pat_nxt    = cmd_in.stipple;
          mask_nxt   = row_mask;
          addr_nxt   = page_base + CALC_W'(cmd_in.pos_x);
          step_nxt   = STEP_BYTE;
          cnt_nxt    = '0;
          state_nxt  = ST_RUN;
          case (cmd_in.cmd)
            CMD_PLOT: begin
              cnt_nxt = CNT_W'(1);
            end
            CMD_HLINE: begin
              cnt_nxt  = hcount;
              addr_nxt = page_base + CALC_W'(hstart);
              step_nxt = STEP_PIXEL;
            end
            CMD_VLINE: begin
              cnt_nxt  = pos_count;
              step_nxt = STEP_ROW;
            end
            CMD_INVERT: begin
              cnt_nxt  = pos_count;
              mask_nxt = 8'hFF;
            end
            CMD_CLEAR: begin
              clr_addr_nxt = '0;
              clr_cmd_nxt  = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            CMD_READ: begin
              cnt_nxt = CNT_W'(1);
              cap_nxt = 1'b1;
            end
            default: begin
              cnt_nxt = '0;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
        mem_req.wdata = 8'h00;
        clr_addr_nxt  = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(STORE_SIZE - 1)) begin
          state_nxt = clr_cmd_r ? ST_FINISH : ST_IDLE;
        end
      end

      ST_RUN: begin
        // Stage 0: issue the read of the next byte
        if (cnt_r != '0) begin
          if (addr_r >= CALC_W'(STORE_SIZE)) begin
            clip_nxt = 1'b1;
            cnt_nxt  = '0;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = addr_r[ADDR_W-1:0];
            s1_v_nxt      = 1'b1;
            s1_addr_nxt   = addr_r[ADDR_W-1:0];
            s1_cap_nxt    = cap_r;
            s1_mask_nxt   = mask_r;
            cnt_nxt       = cnt_r - CNT_W'(1);
            case (step_r)
              STEP_ROW: begin
                mask_nxt = {mask_r[6:0], mask_r[7]};
                if (mask_r[7]) begin
                  addr_nxt = addr_r + CALC_W'(SCREEN_WIDTH);
                end
              end
              STEP_PIXEL: begin
                s1_mask_nxt = pat_r[0] ? mask_r : 8'h00;
                pat_nxt     = {pat_r[0], pat_r[7:1]};
                addr_nxt    = addr_r + CALC_W'(1);
              end
              default: begin
                addr_nxt = addr_r + CALC_W'(1);
              end
            endcase
          end
        end else begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (res_free) begin
          done        = 1'b1;
          clr_cmd_nxt = 1'b0;
          state_nxt   = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign fwd_hit_nxt  = mem_req.we && mem_req.re && (mem_req.waddr == mem_req.raddr);
  assign fwd_data_nxt = mem_req.wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      clr_cmd_r  <= 1'b0;
      cnt_r      <= '0;
      s1_v_r     <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      clr_cmd_r  <= clr_cmd_nxt;
      cnt_r      <= cnt_nxt;
      s1_v_r     <= s1_v_nxt;
      fwd_hit_r  <= fwd_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    mask_r     <= mask_nxt;
    pat_r      <= pat_nxt;
    step_r     <= step_nxt;
    cap_r      <= cap_nxt;
    clip_r     <= clip_nxt;
    rdbyte_r   <= rdbyte_nxt;
    s1_addr_r  <= s1_addr_nxt;
    s1_mask_r  <= s1_mask_nxt;
    s1_cap_r   <= s1_cap_nxt;
    fwd_data_r <= fwd_data_nxt;
  end

  assign stat.idle          = (state_r == ST_IDLE);
  assign stat.done          = done;
  assign stat.res.read_byte = rdbyte_r;
  assign stat.res.clipped   = clip_r;

  // No memory write while waiting for a command
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_req.we)
    else $error("memory write while idle");

  // Stage 1 only holds a byte whose read was issued in the previous cycle
  a_s1_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(mem_req.re))
    else $error("stage 1 valid without a read issued");

  // Forwarding only applies to a byte in stage 1
  a_fwd_in_s1: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> s1_v_r)
    else $error("forward hit without stage 1 byte");

  // The clearing sweep never overlaps a read-modify-write
  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!s1_v_r && !mem_req.re))
    else $error("clear overlaps a read-modify-write");

endmodule

[tb/mono_page_framebuffer_draw_core_test.sv]
`timescale 1ns / 1ps

module mono_page_framebuffer_draw_core_test;
  import mpfd_pkg::*;

  // Spare command codes, decoded as no-ops
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam int RANDOM_ITEMS = 1025;
  localparam int CALM_TAIL    = 150;     // final items run without idling
  localparam int SETTLE       = 140;     // longest run plus margin
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct {
    cmd_in_t    item;
    bit         fixed;   // expectation typed in the table
    res_t       want;
  } stim_row_t;

  logic    clk;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  cmd_in_t in_data   = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  res_t    out_data;

  // Shadow copy of the pixel store and expected results in order
  logic [7:0] shadow_pixels [STORE_SIZE];
  res_t       pending_results [$];
  stim_row_t  directed_rows [$];
  res_t       oldest_exp;

  bit  idling_on  = 1'b0;
  int  error_count = 0;
  int  results_seen = 0;
  int  clipped_seen = 0;
  int  reads_lit    = 0;
  int  stall_left   = 0;
  int  cycle_count  = 0;

  mono_page_framebuffer_draw_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Apply one command to the shadow store and return the result it gives
  function automatic res_t draw_on_shadow(cmd_in_t c);
    res_t        r;
    int unsigned x, y, len8, start, n, base, a, i, row;
    logic [7:0]  pat, mask;
    bit          neg;
    r    = '0;
    x    = 32'(c.pos_x);
    y    = 32'(c.pos_y);
    len8 = 32'($unsigned(c.run_length));
    neg  = c.run_length[7];
    pat  = c.stipple;
    mask = 8'd1 << (y % 8);
    case (c.cmd)
      CMD_PLOT: begin
        a = (y / 8) * SCREEN_WIDTH + x;
        if (a < STORE_SIZE) shadow_pixels[a] ^= mask;
        else r.clipped = 1'b1;
      end
      CMD_HLINE: begin
        start = x;
        n     = len8;
        // leftward run: move the start first, wrapping at 256
        if (neg) begin
          start = (x + len8) % 256;
          n     = 256 - len8;
        end
        base = (y / 8) * SCREEN_WIDTH + start;
        i = 0;
        while (i < n && !r.clipped) begin
          a = base + i;
          if (a >= STORE_SIZE) begin
            r.clipped = 1'b1;
          end else begin
            if (pat[0]) shadow_pixels[a] ^= mask;
            pat = {pat[0], pat[7:1]};
          end
          i++;
        end
      end
      CMD_VLINE: begin
        row = y;
        while (!neg && row < y + len8 && !r.clipped) begin
          a = (row / 8) * SCREEN_WIDTH + x;
          if (a >= STORE_SIZE) r.clipped = 1'b1;
          else shadow_pixels[a] ^= 8'd1 << (row % 8);
          row++;
        end
      end
      CMD_INVERT: begin
        base = (y / 8) * SCREEN_WIDTH + x;
        i = 0;
        while (!neg && i < len8 && !r.clipped) begin
          a = base + i;
          if (a >= STORE_SIZE) r.clipped = 1'b1;
          else shadow_pixels[a] ^= 8'hFF;
          i++;
        end
      end
      CMD_CLEAR: begin
        foreach (shadow_pixels[k]) shadow_pixels[k] = 8'h00;
      end
      CMD_READ: begin
        a = (y / 8) * SCREEN_WIDTH + x;
        if (a < STORE_SIZE) r.read_byte = shadow_pixels[a];
        else r.clipped = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_row(logic [2:0] cmd, int x, int y, int len, logic [7:0] pat,
                         bit fixed, logic [7:0] rb, bit cl);
    stim_row_t row;
    row.item.cmd        = cmd;
    row.item.pos_x      = x[6:0];
    row.item.pos_y      = y[5:0];
    row.item.run_length = len[7:0];
    row.item.stipple    = pat;
    row.fixed           = fixed;
    row.want.read_byte  = rb;
    row.want.clipped    = cl;
    directed_rows.push_back(row);
  endtask

  // Offer one transaction, with an optional gap first, and log its expectation
  task automatic send_cmd(cmd_in_t item, bit fixed, res_t want);
    res_t predicted;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = draw_on_shadow(item);
    pending_results.push_back(fixed ? want : predicted);
  endtask

  // Hold the sender until every outstanding result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  function automatic cmd_in_t random_cmd();
    cmd_in_t c;
    int      pick;
    pick = $urandom_range(0, 99);
    if      (pick < 22) c.cmd = CMD_PLOT;
    else if (pick < 42) c.cmd = CMD_HLINE;
    else if (pick < 57) c.cmd = CMD_VLINE;
    else if (pick < 72) c.cmd = CMD_INVERT;
    else if (pick < 96) c.cmd = CMD_READ;
    else if (pick < 98) c.cmd = $urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7;
    else                c.cmd = CMD_CLEAR;
    c.pos_x   = 7'($urandom);
    c.pos_y   = 6'($urandom);
    c.stipple = 8'($urandom);
    // mostly short runs, some over the full signed range
    if ($urandom_range(0, 9) < 7) c.run_length = 8'($urandom_range(0, 40) - 20);
    else                          c.run_length = 8'($urandom);
    return c;
  endfunction

  // Result side: random stall bursts while idling is on
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: read_byte %h clipped %b",
               out_data.read_byte, out_data.clipped);
        error_count++;
      end else begin
        oldest_exp = pending_results.pop_front();
        results_seen++;
        if (out_data.clipped) clipped_seen++;
        if (out_data.read_byte != 8'h00) reads_lit++;
        if (out_data.read_byte !== oldest_exp.read_byte) begin
          $error("read_byte: expected %h, got %h", oldest_exp.read_byte, out_data.read_byte);
          error_count++;
        end
        if (out_data.clipped !== oldest_exp.clipped) begin
          $error("clipped: expected %b, got %b", oldest_exp.clipped, out_data.clipped);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    res_t none;
    none = '0;
    foreach (shadow_pixels[k]) shadow_pixels[k] = 8'h00;

    //      cmd         x    y    len   pat    fixed byte   clip
    add_row(CMD_READ,     0,   0,    0, 8'h00, 1, 8'h00, 0);  // fresh store reads zero
    add_row(CMD_PLOT,     0,   0,    0, 8'h00, 1, 8'h00, 0);
    add_row(CMD_READ,     0,   0,    0, 8'h00, 1, 8'h01, 0);
    add_row(CMD_PLOT,   127,  63,    0, 8'h00, 1, 8'h00, 0);  // last pixel
    add_row(CMD_READ,   127,  63,    0, 8'h00, 1, 8'h80, 0);
    add_row(CMD_HLINE,    0,   8,  127, 8'hFF, 1, 8'h00, 0);
    add_row(CMD_HLINE,  127,  63,    2, 8'hFF, 1, 8'h00, 1);  // runs off the end
    add_row(CMD_HLINE,    0,   0, -128, 8'hA5, 0, 8'h00, 0);  // leftward, wraps
    add_row(CMD_HLINE,    5,  56,  -10, 8'hFF, 1, 8'h00, 1);  // start lands past end
    add_row(CMD_HLINE,    9,   9,    0, 8'hFF, 1, 8'h00, 0);  // empty run
    add_row(CMD_HLINE,   10,  20,   16, 8'h55, 0, 8'h00, 0);
    add_row(CMD_VLINE,    3,   0,   64, 8'h00, 1, 8'h00, 0);  // full height
    add_row(CMD_VLINE,    3,  60,  127, 8'h00, 1, 8'h00, 1);
    add_row(CMD_VLINE,    4,   4,   -1, 8'h00, 1, 8'h00, 0);  // negative length
    add_row(CMD_VLINE,    4,   4,    0, 8'h00, 1, 8'h00, 0);
    add_row(CMD_INVERT,   0,   0,  127, 8'h00, 1, 8'h00, 0);
    add_row(CMD_INVERT, 120,  63,   10, 8'h00, 1, 8'h00, 1);
    add_row(CMD_INVERT,   0,   0, -128, 8'h00, 1, 8'h00, 0);
    add_row(CMD_READ,     3,   0,    0, 8'h00, 0, 8'h00, 0);
    add_row(CMD_READ,     1,  16,    0, 8'h00, 0, 8'h00, 0);
    add_row(CMD_SPARE6, 127,  63,   -1, 8'hFF, 1, 8'h00, 0);
    add_row(CMD_SPARE7,  55,  33,  100, 8'h0F, 1, 8'h00, 0);
    add_row(CMD_CLEAR,    0,   0,    0, 8'h00, 1, 8'h00, 0);
    add_row(CMD_READ,   127,  63,    0, 8'h00, 1, 8'h00, 0);
    add_row(CMD_READ,     0,   0,    0, 8'h00, 1, 8'h00, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table, with idling already on
    idling_on = 1'b1;
    foreach (directed_rows[r])
      send_cmd(directed_rows[r].item, directed_rows[r].fixed, directed_rows[r].want);
    drain_results();

    // Random commands: idling on in two of every three stretches, off at the end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idling_on = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 100) % 3 != 2);
      if (n % 250 == 125) drain_results();
      send_cmd(random_cmd(), 1'b0, none);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Covered %0d table rows and %0d random commands over %0d cycles.",
             directed_rows.size(), RANDOM_ITEMS, cycle_count);
    $display("Checked %0d results: %0d clipped, %0d reads of lit bytes.",
             results_seen, clipped_seen, reads_lit);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/mpfd_pkg.sv
rtl/mpfd_ram.sv
rtl/mpfd_engine.sv
rtl/mono_page_framebuffer_draw_core.sv
tb/mono_page_framebuffer_draw_core_test.sv
